// ===== hdl/bba_pkg.sv =====
// Shared types, codes and helpers for the buddy block allocator.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package bba_pkg;

	// Fixed widths set by the request and result fields.
	localparam int ORD_W = 5;   // order, depth and free-space code; holds 0..31
	localparam int OFF_W = 15;  // unit offset; pool order never exceeds 15
	localparam int SIZE_W = 11;
	localparam int REL_W = 10;
	localparam int BOFF_W = 10;
	localparam int BORD_W = 4;
	localparam int CFG_W = 4;

	localparam int TREE_LEVELS_DEF = 10;
	localparam logic [CFG_W-1:0] POOL_ORDER_RESET = 4'd10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [1:0] {
		NS_UNUSED = 2'd0,
		NS_FREE   = 2'd1,
		NS_SPLIT  = 2'd2,
		NS_ALLOC  = 2'd3
	} node_st_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_SIZE = 2'd1,
		STAT_NO_SPACE = 2'd2,
		STAT_BAD_FREE = 2'd3
	} status_t;

	// One child of a node: its status and the largest free order below it, plus one
	// (zero means no free block in that subtree).
	typedef struct packed {
		node_st_t st;
		logic [ORD_W-1:0] av;
	} half_t;

	// One memory row per internal node, holding both of its children.
	typedef struct packed {
		half_t l;
		half_t r;
	} row_t;

	typedef struct packed {
		logic op;
		logic [SIZE_W-1:0] size;
		logic [REL_W-1:0] rel;
	} req_t;

	typedef struct packed {
		logic [BOFF_W-1:0] offset;
		logic [BORD_W-1:0] order;
		status_t status;
	} res_t;

	typedef struct packed {
		logic load;
		logic [ORD_W-1:0] ord;
	} cfg_t;

	// Round a size up to the next power of two and return its log2.
	function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
		logic [ORD_W-1:0] msb;
		logic rest;
		msb = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (size[i]) begin
				msb = ORD_W'(i);
			end
		end
		rest = (size & (size - SIZE_W'(1))) != '0;
		return msb + ORD_W'(rest);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/buddy_block_allocator.sv =====
// Buddy block allocator, top level. A size or offset out of range is answered without
// touching the node memory; otherwise the walker reads the split levels down to a block
// and then writes each parent row on the climb back to the root.
// One request is in work at a time: each tree level costs one read of the node memory
// going down and one write going up. The next request is taken the cycle after
// the result enters the output register. Reset: root free at pool order 10, no clearing pass.
`default_nettype none

module buddy_block_allocator #(
	parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [3:0]   cfg_wr_data,  // pool_order
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [23:0]  s_tdata,      // request_size[10:0], release_offset[20:11], zero
	input  wire logic [0:0]   s_tuser,      // operation
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,      // block_offset[9:0], block_order[13:10], zero
	output logic [1:0]        m_tuser       // status
);

	localparam int ORD_W = bba_pkg::ORD_W;

	logic [bba_pkg::CFG_W-1:0] pool_q;
	logic [ORD_W-1:0] pool_ord;
	bba_pkg::cfg_t cfg;
	bba_pkg::req_t req;
	logic res_valid;
	logic res_ready;
	bba_pkg::res_t res;
	logic out_valid_q;
	bba_pkg::res_t out_q;

	always_comb begin
		// clamp to the depth of the tree
		pool_ord = (ORD_W'(pool_q) > ORD_W'(TREE_LEVELS)) ? ORD_W'(TREE_LEVELS) : ORD_W'(pool_q);
		cfg.load = cfg_wr_en;
		cfg.ord = (ORD_W'(cfg_wr_data) > ORD_W'(TREE_LEVELS)) ?
			ORD_W'(TREE_LEVELS) : ORD_W'(cfg_wr_data);
		req.op = s_tuser[0];
		req.size = s_tdata[10:0];
		req.rel = s_tdata[20:11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= bba_pkg::POOL_ORDER_RESET;
		end else if (cfg_wr_en) begin
			pool_q <= cfg_wr_data;
		end
	end

	bba_walker #(
		.TREE_LEVELS(TREE_LEVELS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pool_ord (pool_ord),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register: hold a result until the downstream side takes it
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_q.order, out_q.offset};
	assign m_tuser = out_q.status;

endmodule

`default_nettype wire

// ===== hdl/bba_row_ram.sv =====
// Node-pair memory of the allocator: one row per internal tree node.
// Uses bba_pkg::row_t; one write port, one read port with registered data.
`default_nettype none

module bba_row_ram #(
	parameter int ADDR_W = bba_pkg::TREE_LEVELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [ADDR_W-1:0]  wr_addr,
	input  wire bba_pkg::row_t      wr_data,
	input  wire logic [ADDR_W-1:0]  rd_addr,
	output bba_pkg::row_t           rd_data
);

	localparam int DEPTH = 2 ** ADDR_W;

	bba_pkg::row_t mem [0:DEPTH-1];
	bba_pkg::row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/bba_walker.sv =====
// Tree walker: descends the node memory to find a block, then climbs back to the root
// rewriting each parent row. Depends on bba_pkg and bba_row_ram.
`default_nettype none

module bba_walker #(
	parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bba_pkg::cfg_t              cfg,
	input  wire logic [bba_pkg::ORD_W-1:0]  pool_ord,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire bba_pkg::req_t              req,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output bba_pkg::res_t                   res
);

	localparam int L = TREE_LEVELS;
	localparam int NODE_W = L + 1;
	localparam int SD_W = (L > 1) ? $clog2(L) : 1;
	localparam int ORD_W = bba_pkg::ORD_W;
	localparam int OFF_W = bba_pkg::OFF_W;
	localparam int PSZ_W = OFF_W + 2;
	localparam logic [ORD_W-1:0] RESET_ORD =
		(int'(bba_pkg::POOL_ORDER_RESET) > L) ? ORD_W'(L) : ORD_W'(bba_pkg::POOL_ORDER_RESET);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DESC  = 5'b00010,
		S_FOUND = 5'b00100,
		S_UP    = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	logic op_q;
	logic [ORD_W-1:0] k_q;
	logic [OFF_W-1:0] rel_q;
	logic [OFF_W-1:0] off_q;
	logic [NODE_W-1:0] node_q;
	logic [ORD_W-1:0] dep_q;
	logic [ORD_W-1:0] ord_q;
	bba_pkg::node_st_t st_q;
	logic [ORD_W-1:0] df_q;
	bba_pkg::node_st_t root_st_q;
	logic [ORD_W-1:0] root_av_q;
	logic [NODE_W-1:0] c_node_q;
	logic [ORD_W-1:0] c_dep_q;
	logic [ORD_W-1:0] c_ord_q;
	bba_pkg::node_st_t c_st_q;
	logic [ORD_W-1:0] c_av_q;
	bba_pkg::res_t res_q;
	bba_pkg::row_t stack_q [0:L-1];

	// memory port
	logic wr_en;
	logic [L-1:0] wr_addr;
	bba_pkg::row_t wr_data;
	logic [L-1:0] rd_addr;
	bba_pkg::row_t rd_data;

	// request intake
	logic [PSZ_W-1:0] pool_sz;
	logic [ORD_W-1:0] req_k;
	logic size_bad;
	logic rel_bad;
	logic no_space;

	// descent
	logic [ORD_W-1:0] oc;
	logic go_right;
	bba_pkg::half_t pick;
	logic [NODE_W-1:0] child;

	// found block
	logic [NODE_W-1:0] tgt;
	logic aligned;

	// climb
	logic [ORD_W-1:0] dep_m1;
	logic [ORD_W-1:0] par_ord;
	bba_pkg::row_t stk;
	logic sib_new;
	bba_pkg::half_t ch;
	bba_pkg::half_t up_l;
	bba_pkg::half_t up_r;
	logic merge;
	logic [NODE_W-1:0] par_node;

	bba_row_ram #(
		.ADDR_W(L)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		pool_sz = PSZ_W'(1) << pool_ord;
		req_k = bba_pkg::size_order(req.size);
		size_bad = (req.size == '0) || (PSZ_W'(req.size) > pool_sz);
		rel_bad = PSZ_W'(req.rel) >= pool_sz;
		no_space = root_av_q < (req_k + ORD_W'(1));

		oc = ord_q - ORD_W'(1);
		if (op_q == bba_pkg::OP_ALLOC) begin
			go_right = rd_data.l.av < (k_q + ORD_W'(1));
		end else begin
			go_right = rel_q[oc[3:0]];
		end
		pick = go_right ? rd_data.r : rd_data.l;
		child = {node_q[L-1:0], 1'b0} + NODE_W'(1) + NODE_W'(go_right);
		rd_addr = (state_q == S_DESC) ? child[L-1:0] : '0;

		tgt = ((node_q + NODE_W'(1)) << (ord_q - k_q)) - NODE_W'(1);
		aligned = (rel_q & ((OFF_W'(1) << ord_q) - OFF_W'(1))) == '0;

		dep_m1 = c_dep_q - ORD_W'(1);
		par_ord = c_ord_q + ORD_W'(1);
		stk = stack_q[dep_m1[SD_W-1:0]];
		// rows below the block that was split are new: the right half is a fresh free buddy
		sib_new = (op_q == bba_pkg::OP_ALLOC) && (dep_m1 >= df_q);
		ch.st = c_st_q;
		ch.av = c_av_q;
		if (c_node_q[0]) begin
			up_l = ch;
			if (sib_new) begin
				up_r.st = bba_pkg::NS_FREE;
				up_r.av = par_ord;
			end else begin
				up_r = stk.r;
			end
		end else begin
			up_l = stk.l;
			up_r = ch;
		end
		merge = (up_l.st == bba_pkg::NS_FREE) && (up_r.st == bba_pkg::NS_FREE);
		par_node = (c_node_q - NODE_W'(1)) >> 1;

		wr_en = (state_q == S_UP) && (c_dep_q != '0);
		wr_addr = par_node[L-1:0];
		if (merge) begin
			wr_data = '0;
		end else begin
			wr_data.l = up_l;
			wr_data.r = up_r;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DESC) begin
			stack_q[dep_q[SD_W-1:0]] <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			root_st_q <= bba_pkg::NS_FREE;
			root_av_q <= RESET_ORD + ORD_W'(1);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.op;
						k_q <= req_k;
						rel_q <= OFF_W'(req.rel);
						off_q <= '0;
						node_q <= '0;
						dep_q <= '0;
						ord_q <= pool_ord;
						st_q <= root_st_q;
						res_q.offset <= '0;
						res_q.order <= '0;
						if (req.op == bba_pkg::OP_ALLOC && size_bad) begin
							res_q.status <= bba_pkg::STAT_BAD_SIZE;
							state_q <= S_RESP;
						end else if (req.op == bba_pkg::OP_ALLOC && no_space) begin
							res_q.status <= bba_pkg::STAT_NO_SPACE;
							state_q <= S_RESP;
						end else if (req.op == bba_pkg::OP_FREE && rel_bad) begin
							res_q.status <= bba_pkg::STAT_BAD_FREE;
							state_q <= S_RESP;
						end else if (root_st_q == bba_pkg::NS_SPLIT) begin
							state_q <= S_DESC;
						end else begin
							state_q <= S_FOUND;
						end
					end
				end
				S_DESC: begin
					node_q <= child;
					dep_q <= dep_q + ORD_W'(1);
					ord_q <= oc;
					st_q <= pick.st;
					if (go_right) begin
						off_q <= off_q | (OFF_W'(1) << oc);
					end
					if (pick.st != bba_pkg::NS_SPLIT) begin
						state_q <= S_FOUND;
					end
				end
				S_FOUND: begin
					df_q <= dep_q;
					if (op_q == bba_pkg::OP_ALLOC) begin
						// split down the left edge to the requested order
						c_node_q <= tgt;
						c_dep_q <= dep_q + ord_q - k_q;
						c_ord_q <= k_q;
						c_st_q <= bba_pkg::NS_ALLOC;
						c_av_q <= '0;
						res_q.offset <= off_q[bba_pkg::BOFF_W-1:0];
						res_q.order <= k_q[bba_pkg::BORD_W-1:0];
						res_q.status <= bba_pkg::STAT_OK;
						state_q <= S_UP;
					end else if (st_q == bba_pkg::NS_ALLOC && aligned) begin
						c_node_q <= node_q;
						c_dep_q <= dep_q;
						c_ord_q <= ord_q;
						c_st_q <= bba_pkg::NS_FREE;
						c_av_q <= ord_q + ORD_W'(1);
						res_q.order <= ord_q[bba_pkg::BORD_W-1:0];
						res_q.status <= bba_pkg::STAT_OK;
						state_q <= S_UP;
					end else begin
						res_q.status <= bba_pkg::STAT_BAD_FREE;
						state_q <= S_RESP;
					end
				end
				S_UP: begin
					if (c_dep_q == '0) begin
						state_q <= S_RESP;
					end else begin
						c_node_q <= par_node;
						c_dep_q <= dep_m1;
						c_ord_q <= par_ord;
						if (merge) begin
							c_st_q <= bba_pkg::NS_FREE;
							c_av_q <= par_ord + ORD_W'(1);
						end else begin
							c_st_q <= bba_pkg::NS_SPLIT;
							c_av_q <= (up_l.av > up_r.av) ? up_l.av : up_r.av;
						end
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// a new pool order forgets every grant: only the root is ever read first
			if (cfg.load) begin
				root_st_q <= bba_pkg::NS_FREE;
				root_av_q <= cfg.ord + ORD_W'(1);
			end else if (state_q == S_UP && c_dep_q == '0) begin
				root_st_q <= c_st_q;
				root_av_q <= c_av_q;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res = res_q;

endmodule

`default_nettype wire

// ===== verif/tb_buddy_block_allocator.sv =====
// Self-checking testbench for the buddy block allocator: random and directed alloc/free
// requests, checked against a predictor of the node tree kept in this file.
// Depends on bba_pkg (hdl/bba_pkg.sv) and the buddy_block_allocator top level.
`default_nettype none

module tb_buddy_block_allocator;

	localparam int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF;
	localparam int NODES = (2 << TREE_LEVELS) - 1;
	localparam int SIZE_W = bba_pkg::SIZE_W;
	localparam int REL_W = bba_pkg::REL_W;
	localparam int BOFF_W = bba_pkg::BOFF_W;
	localparam int BORD_W = bba_pkg::BORD_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;  // request_size[10:0], release_offset[20:11], zero
	logic [0:0] s_tuser = '0;   // operation
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;       // block_offset[9:0], block_order[13:10], zero
	logic [1:0] m_tuser;        // status

	buddy_block_allocator #(.TREE_LEVELS(TREE_LEVELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: node tree in heap order, pool order register, offsets granted so far
	bba_pkg::node_st_t tree_st [NODES];
	logic [bba_pkg::CFG_W-1:0] pool_cfg = bba_pkg::POOL_ORDER_RESET;
	int live_offsets[$];

	bba_pkg::req_t pending_reqs[$];
	bba_pkg::res_t due_results[$];
	int mismatches = 0;
	bit quiet = 1'b0;
	int gap_tx = 0;
	int gap_rx = 0;

	function automatic void tree_clear();
		foreach (tree_st[i]) begin
			tree_st[i] = bba_pkg::NS_UNUSED;
		end
		tree_st[0] = bba_pkg::NS_FREE;
		live_offsets.delete();
	endfunction

	function automatic int pool_log2();
		return (pool_cfg > TREE_LEVELS) ? TREE_LEVELS : int'(pool_cfg);
	endfunction

	// Walk down split nodes to the block that covers off.
	function automatic void find_block(input int off, input int p, output int node,
			output int ord);
		int n;
		int o;
		int child;
		n = 0;
		o = p;
		while (o > 0 && tree_st[n] == bba_pkg::NS_SPLIT) begin
			o--;
			child = 2 * n + 1 + ((off >> o) & 1);
			if (child >= NODES) begin
				o++;
				break;
			end
			n = child;
		end
		node = n;
		ord = o;
	endfunction

	function automatic bba_pkg::res_t apply_request(input bba_pkg::req_t rq);
		bba_pkg::res_t res;
		int p;
		int pool;
		int k;
		int off;
		int node;
		int ord;
		int buddy;
		int parent;
		bit found;
		res = '0;
		res.status = bba_pkg::STAT_OK;
		p = pool_log2();
		pool = 1 << p;
		if (rq.op == bba_pkg::OP_ALLOC) begin
			if (rq.size == 0 || int'(rq.size) > pool) begin
				res.status = bba_pkg::STAT_BAD_SIZE;
				return res;
			end
			k = 0;
			while ((1 << k) < int'(rq.size)) k++;
			off = 0;
			found = 1'b0;
			while (off < pool) begin
				find_block(off, p, node, ord);
				if (tree_st[node] == bba_pkg::NS_FREE && ord >= k) begin
					found = 1'b1;
					break;
				end
				off += 1 << ord;
			end
			if (!found) begin
				res.status = bba_pkg::STAT_NO_SPACE;
				return res;
			end
			// split down, keeping the left half each time
			while (ord > k) begin
				tree_st[node] = bba_pkg::NS_SPLIT;
				tree_st[2 * node + 1] = bba_pkg::NS_FREE;
				tree_st[2 * node + 2] = bba_pkg::NS_FREE;
				node = 2 * node + 1;
				ord--;
			end
			tree_st[node] = bba_pkg::NS_ALLOC;
			res.offset = BOFF_W'(off);
			res.order = BORD_W'(k);
			live_offsets.push_back(off);
		end else begin
			if (int'(rq.rel) >= pool) begin
				res.status = bba_pkg::STAT_BAD_FREE;
				return res;
			end
			find_block(int'(rq.rel), p, node, ord);
			if (tree_st[node] != bba_pkg::NS_ALLOC ||
					(int'(rq.rel) & ((1 << ord) - 1)) != 0) begin
				res.status = bba_pkg::STAT_BAD_FREE;
				return res;
			end
			res.order = BORD_W'(ord);
			tree_st[node] = bba_pkg::NS_FREE;
			// merge upward while the buddy is free too
			while (node > 0) begin
				buddy = (node & 1) ? node + 1 : node - 1;
				parent = (node - 1) / 2;
				if (tree_st[buddy] != bba_pkg::NS_FREE) break;
				tree_st[node] = bba_pkg::NS_UNUSED;
				tree_st[buddy] = bba_pkg::NS_UNUSED;
				tree_st[parent] = bba_pkg::NS_FREE;
				node = parent;
			end
			foreach (live_offsets[i]) begin
				if (live_offsets[i] == int'(rq.rel)) begin
					live_offsets.delete(i);
					break;
				end
			end
		end
		return res;
	endfunction

	function automatic bba_pkg::req_t mk_req(input logic op, input int size, input int rel);
		bba_pkg::req_t rq;
		rq.op = op;
		rq.size = SIZE_W'(size);
		rq.rel = REL_W'(rel);
		return rq;
	endfunction

	// Request driver: hold a request until taken, insert short gaps between requests.
	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (gap_tx > 0) begin
				gap_tx--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				bba_pkg::req_t rq;
				rq = pending_reqs.pop_front();
				s_tdata <= {3'b000, rq.rel, rq.size};
				s_tuser <= rq.op;
				s_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) gap_tx = $urandom_range(1, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure in random bursts, none while quiet is set.
	always @(posedge clk) begin
		if (arst_n) begin
			if (gap_rx > 0) begin
				gap_rx--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				gap_rx = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Predict at each accepted request.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			due_results.push_back(apply_request(mk_req(s_tuser[0], int'(s_tdata[10:0]),
				int'(s_tdata[20:11]))));
		end
	end

	function automatic void check_field(input string name, input int exp_v, input logic [9:0] got);
		if (got !== 10'(exp_v)) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got offset %0d order %0d status %0d",
					$time, m_tdata[9:0], m_tdata[13:10], m_tuser);
				mismatches++;
			end else begin
				bba_pkg::res_t exp_r;
				exp_r = due_results.pop_front();
				check_field("block_offset", int'(exp_r.offset), m_tdata[9:0]);
				check_field("block_order", int'(exp_r.order), 10'(m_tdata[13:10]));
				check_field("status", int'(exp_r.status), 10'(m_tuser));
			end
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || due_results.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
	endtask

	task automatic write_pool_order(input int v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 4'(v);
		pool_cfg = 4'(v);
		tree_clear();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int n);
		int p;
		int pool;
		int k;
		int roll;
		int made;
		bba_pkg::req_t rq;
		made = 0;
		while (made < n) begin
			@(negedge clk);
			if (pending_reqs.size() >= 2) continue;
			p = pool_log2();
			pool = 1 << p;
			rq.op = bba_pkg::OP_ALLOC;
			rq.size = SIZE_W'($urandom_range(0, 2047));
			rq.rel = REL_W'($urandom_range(0, 1023));
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				rq.op = 1'($urandom_range(0, 1));
			end else if (roll < 12) begin
				rq.size = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(pool + 1, 2047));
			end else if (roll < 56 && live_offsets.size() > 0) begin
				rq.op = bba_pkg::OP_FREE;
				rq.rel = REL_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
				// now and then aim just past the start of a granted block instead of at it
				if ($urandom_range(0, 9) == 0) rq.rel = rq.rel + REL_W'($urandom_range(1, 3));
			end else begin
				k = $urandom_range(0, p);
				if (k > 3 && $urandom_range(0, 2) != 0) k = $urandom_range(0, 3);
				rq.size = (k == 0) ? SIZE_W'(1) :
					SIZE_W'($urandom_range((1 << (k - 1)) + 1, 1 << k));
			end
			pending_reqs.push_back(rq);
			made++;
		end
	endtask

	initial begin
		tree_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// full pool at the reset order
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 0, 1023));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1025, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 2047, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1024, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 2047, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1, 1023));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 3, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 2, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 1));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 5));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 4));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 2));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 512, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 512, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 512));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 1023));
		run_random(150);

		// single-unit pool
		write_pool_order(0);
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 1, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_ALLOC, 2, 0));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 1));
		pending_reqs.push_back(mk_req(bba_pkg::OP_FREE, 0, 0));
		run_random(60);

		// register above the tree depth saturates
		write_pool_order(15);
		run_random(150);
		write_pool_order(1);
		run_random(120);
		write_pool_order(5);
		run_random(150);
		write_pool_order(11);
		run_random(120);
		write_pool_order($urandom_range(0, 15));
		run_random(120);

		// no idling on either side from here on
		quiet = 1'b1;
		write_pool_order(10);
		run_random(130);

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_buddy_block_allocator: PASS");
		end else begin
			$display("tb_buddy_block_allocator: FAIL");
		end
		$finish;
	end

	initial begin
		#(20 * 600000);
		$display("tb_buddy_block_allocator: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
